/* rtl/fapc_pkg.sv */
// Shared types and constants for the four-axis PID controller core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fapc_pkg;

   // Q8.8 sample width of every input and output field
   localparam int DATA_WIDTH = 16;
   localparam int AXES       = 4;

   // Q4.12 gains and the shift back to Q8.8
   localparam int GAIN_W     = 16;
   localparam int GAIN_SHIFT = 12;

   // Integrator is a 16-bit Q8.8 value clamped to +/-100.0
   localparam int INT_W   = 16;
   localparam int ERR_W   = DATA_WIDTH + 1;
   localparam int DER_W   = ERR_W + 1;
   localparam int ISUM_W  = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;

   // Product and accumulator widths
   localparam int P_W     = GAIN_W + ERR_W;
   localparam int I_W     = GAIN_W + INT_W;
   localparam int D_W     = GAIN_W + DER_W;
   localparam int ACCUM_W = D_W + 2;
   localparam int SH_W    = ACCUM_W - GAIN_SHIFT;

   // Stream word widths
   localparam int REQ_TDATA_W = ((2 * AXES * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((AXES * DATA_WIDTH + 7) / 8) * 8;

   localparam int CSR_COUNT   = 8;
   localparam int CSR_INDEX_W = 3;

   typedef logic signed [DATA_WIDTH-1:0] sample_type;
   typedef logic signed [GAIN_W-1:0]     gain_type;
   typedef logic signed [ACCUM_W-1:0]    accum_type;

   // Configuration register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_XY  = 3'd0,
      CSR_KI_XY  = 3'd1,
      CSR_KD_XY  = 3'd2,
      CSR_KP_Z   = 3'd3,
      CSR_KI_Z   = 3'd4,
      CSR_KD_Z   = 3'd5,
      CSR_KP_YAW = 3'd6,
      CSR_KI_YAW = 3'd7
   } fapc_csr_type;

   localparam gain_type GAIN_RESET [CSR_COUNT] = '{
      16'sd1638, 16'sd41, 16'sd205, 16'sd410, 16'sd0, 16'sd0, 16'sd0, 16'sd0
   };

   // Integrator clamp, +/-100.0 in Q8.8
   localparam logic signed [INT_W-1:0] INT_MAX = 16'sd25600;
   localparam logic signed [INT_W-1:0] INT_MIN = -16'sd25600;

   // Output saturation limits at the shifted width
   localparam logic signed [SH_W-1:0] OUT_MAX =
      {{(SH_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [SH_W-1:0] OUT_MIN = ~OUT_MAX;

   // Per-stage load strobes shared by all lanes
   typedef struct packed {
      logic load1;
      logic load2;
   } fapc_stage_ctl_type;

endpackage : fapc_pkg

`default_nettype wire

/* rtl/four_axis_pid_controller_core.sv */
// Four-axis PID controller core: gain registers, four axis lanes and the
// output merge stage. Depends on fapc_pkg, fapc_lane and fapc_merge.
//
// Usage:
//   req_* carries one word per control tick: measured x, y, z, yaw and
//   target x, y, z, yaw, all signed Q8.8. rsp_* returns one word per
//   request: vel_x, vel_y, vel_z, yaw_rate, signed Q8.8, saturated.
//   csr_* writes the eight Q4.12 gains; write only while no word is in
//   flight.
//   A word accepted on req_* passes the error stage, the product stage and
//   the output register in that order before it shows on rsp_*.
//   Throughput is one word per cycle while rsp_tready stays high; each lane
//   updates its integrator and previous error as the word enters the error
//   stage, so consecutive words never wait on each other.
//   When rsp_tready is low, the output register holds its word and the two
//   inner stages keep filling; req_tready drops only once all three are full.
//   Reset clears integrators, previous errors and pipeline valids and loads
//   the default gains.
`timescale 1ns / 1ps
`default_nettype none

module four_axis_pid_controller_core (
   input  wire                                clock,
   input  wire                                reset,
   // meas_x, meas_y, meas_z, meas_yaw, target_x, target_y, target_z,
   // target_yaw from bit 0 up
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [fapc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // vel_x, vel_y, vel_z, yaw_rate from bit 0 up
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [fapc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire                                csr_we,
   input  wire [fapc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire [fapc_pkg::GAIN_W-1:0]         csr_wdata
);
   import fapc_pkg::*;

   gain_type gain_ff [CSR_COUNT];
   gain_type gain_in [CSR_COUNT];

   logic v1_ff, v1_in, v2_ff, v2_in;
   logic ready1, ready2, ready3;
   fapc_stage_ctl_type ctl;
   accum_type lane_sum [AXES];

   // Gain register writes
   always_comb begin
      for (int r = 0; r < CSR_COUNT; r++) begin
         gain_in[r] = gain_ff[r];
      end
      if (csr_we) begin
         unique case (fapc_csr_type'(csr_index))
            CSR_KP_XY:  gain_in[CSR_KP_XY]  = csr_wdata;
            CSR_KI_XY:  gain_in[CSR_KI_XY]  = csr_wdata;
            CSR_KD_XY:  gain_in[CSR_KD_XY]  = csr_wdata;
            CSR_KP_Z:   gain_in[CSR_KP_Z]   = csr_wdata;
            CSR_KI_Z:   gain_in[CSR_KI_Z]   = csr_wdata;
            CSR_KD_Z:   gain_in[CSR_KD_Z]   = csr_wdata;
            CSR_KP_YAW: gain_in[CSR_KP_YAW] = csr_wdata;
            CSR_KI_YAW: gain_in[CSR_KI_YAW] = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < CSR_COUNT; r++) begin
            gain_ff[r] <= GAIN_RESET[r];
         end
      end else begin
         for (int r = 0; r < CSR_COUNT; r++) begin
            gain_ff[r] <= gain_in[r];
         end
      end
   end

   // Pipeline flow: each stage moves when the next one has room
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;
   assign ctl.load1  = req_tvalid && ready1;
   assign ctl.load2  = v1_ff && ready2;
   assign v1_in      = ready1 ? req_tvalid : v1_ff;
   assign v2_in      = ready2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Axis lanes; x and y share gains, yaw has no derivative term
   fapc_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .meas   (req_tdata[0*DATA_WIDTH +: DATA_WIDTH]),
      .target (req_tdata[4*DATA_WIDTH +: DATA_WIDTH]),
      .kp     (gain_ff[CSR_KP_XY]),
      .ki     (gain_ff[CSR_KI_XY]),
      .kd     (gain_ff[CSR_KD_XY]),
      .sum    (lane_sum[0])
   );

   fapc_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .meas   (req_tdata[1*DATA_WIDTH +: DATA_WIDTH]),
      .target (req_tdata[5*DATA_WIDTH +: DATA_WIDTH]),
      .kp     (gain_ff[CSR_KP_XY]),
      .ki     (gain_ff[CSR_KI_XY]),
      .kd     (gain_ff[CSR_KD_XY]),
      .sum    (lane_sum[1])
   );

   fapc_lane u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .meas   (req_tdata[2*DATA_WIDTH +: DATA_WIDTH]),
      .target (req_tdata[6*DATA_WIDTH +: DATA_WIDTH]),
      .kp     (gain_ff[CSR_KP_Z]),
      .ki     (gain_ff[CSR_KI_Z]),
      .kd     (gain_ff[CSR_KD_Z]),
      .sum    (lane_sum[2])
   );

   fapc_lane u_lane_yaw (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .meas   (req_tdata[3*DATA_WIDTH +: DATA_WIDTH]),
      .target (req_tdata[7*DATA_WIDTH +: DATA_WIDTH]),
      .kp     (gain_ff[CSR_KP_YAW]),
      .ki     (gain_ff[CSR_KI_YAW]),
      .kd     ('0),
      .sum    (lane_sum[3])
   );

   // Merge lanes into the result word
   fapc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v2_ff),
      .in_ready   (ready3),
      .lane_sum   (lane_sum),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // An empty output register always leaves room for a new request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output register");

endmodule : four_axis_pid_controller_core

`default_nettype wire

/* rtl/fapc_lane.sv */
// One axis lane: error, clamped integrator and derivative, then the three
// gain products. Depends on fapc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fapc_lane (
   input  wire                         clock,
   input  wire                         reset,
   input  fapc_pkg::fapc_stage_ctl_type ctl,
   input  fapc_pkg::sample_type        meas,
   input  fapc_pkg::sample_type        target,
   input  fapc_pkg::gain_type          kp,
   input  fapc_pkg::gain_type          ki,
   input  fapc_pkg::gain_type          kd,
   output fapc_pkg::accum_type         sum
);
   import fapc_pkg::*;

   // Axis state; between load1 and load2 it doubles as the stage 1 payload
   logic signed [INT_W-1:0]  integ_ff, integ_in;
   logic signed [ERR_W-1:0]  prev_err_ff, err_in;
   logic signed [DER_W-1:0]  der_ff, der_in;
   logic signed [ISUM_W-1:0] isum;

   logic signed [P_W-1:0] p_ff, p_in;
   logic signed [I_W-1:0] i_ff, i_in;
   logic signed [D_W-1:0] d_ff, d_in;

   // Stage 1: error, integrator with clamp, derivative
   always_comb begin
      err_in = ERR_W'(target) - ERR_W'(meas);
      isum   = ISUM_W'(integ_ff) + ISUM_W'(err_in);
      priority if (isum >= ISUM_W'(INT_MAX)) begin
         integ_in = INT_MAX;
      end else if (isum <= ISUM_W'(INT_MIN)) begin
         integ_in = INT_MIN;
      end else begin
         integ_in = isum[INT_W-1:0];
      end
      der_in = DER_W'(err_in) - DER_W'(prev_err_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_err_ff <= '0;
      end else if (ctl.load1) begin
         integ_ff    <= integ_in;
         prev_err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         der_ff <= der_in;
      end
   end

   // Stage 2: gain products
   assign p_in = P_W'(kp) * P_W'(prev_err_ff);
   assign i_in = I_W'(ki) * I_W'(integ_ff);
   assign d_in = D_W'(kd) * D_W'(der_ff);

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         p_ff <= p_in;
         i_ff <= i_in;
         d_ff <= d_in;
      end
   end

   assign sum = ACCUM_W'(p_ff) + ACCUM_W'(i_ff) + ACCUM_W'(d_ff);

   // Integrator never leaves the clamp window
   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= INT_MAX) && (integ_ff >= INT_MIN))
      else $error("integrator outside clamp window");

   // State only moves on an accepted word
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.load1 |=> $stable(integ_ff) && $stable(prev_err_ff))
      else $error("axis state changed without an accepted word");

   // Derivative is the step of the stored error
   a_der_step: assert property (@(posedge clock) disable iff (reset)
      ctl.load1 |=> der_ff == (DER_W'(prev_err_ff) - DER_W'($past(prev_err_ff))))
      else $error("derivative does not match error step");

endmodule : fapc_lane

`default_nettype wire

/* rtl/fapc_merge.sv */
// Output stage: shifts each lane sum back to Q8.8, saturates, packs the
// four axes into one result word and holds it. Depends on fapc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fapc_merge (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  fapc_pkg::accum_type            lane_sum [fapc_pkg::AXES],
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // vel_x, vel_y, vel_z, yaw_rate from bit 0 up, zero padded
   output logic [fapc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import fapc_pkg::*;

   logic                   valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] data_ff, data_in;

   // Floor shift and saturation per lane
   always_comb begin
      logic signed [SH_W-1:0] shifted;
      data_in = '0;
      for (int ax = 0; ax < AXES; ax++) begin
         shifted = lane_sum[ax][ACCUM_W-1:GAIN_SHIFT];
         priority if (shifted > OUT_MAX) begin
            data_in[ax*DATA_WIDTH +: DATA_WIDTH] = OUT_MAX[DATA_WIDTH-1:0];
         end else if (shifted < OUT_MIN) begin
            data_in[ax*DATA_WIDTH +: DATA_WIDTH] = OUT_MIN[DATA_WIDTH-1:0];
         end else begin
            data_in[ax*DATA_WIDTH +: DATA_WIDTH] = shifted[DATA_WIDTH-1:0];
         end
      end
   end

   // Output register, free when empty or being taken
   assign in_ready = !valid_ff || rsp_tready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule : fapc_merge

`default_nettype wire

/* test/tb_four_axis_pid_controller_core.sv */
// Self-checking testbench for four_axis_pid_controller_core: stream words in, per-axis PID
// outputs checked against an in-bench model of integrator, derivative and gain arithmetic.
// Depends on fapc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_four_axis_pid_controller_core;
   import fapc_pkg::*;

   localparam int PIPE_LATENCY = 3;
   localparam int LONG_HOLD    = 120;
   localparam int HOLD_AT      = 150;
   localparam int REPORT_MAX   = 10;

   typedef logic [REQ_TDATA_W-1:0] cmd_word_type;
   typedef logic [RSP_TDATA_W-1:0] vel_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   cmd_word_type req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   vel_word_type rsp_tdata;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   gain_type               csr_wdata = '0;

   four_axis_pid_controller_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Model state: gains, integrators and last errors
   gain_type gain_reg [CSR_COUNT] = GAIN_RESET;
   longint   integ_q88 [AXES] = '{default: 0};
   longint   last_err  [AXES] = '{default: 0};

   cmd_word_type pending_cmds [$];
   vel_word_type expected_vel [$];

   bit idle_on       = 1'b1;
   int failures      = 0;
   int words_taken   = 0;
   int results_seen  = 0;
   int gain_settings = 1;

   string axis_name [AXES] = '{"vel_x", "vel_y", "vel_z", "yaw_rate"};

   // Clock and reset
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Advance the PID model by one word and return the velocity word
   function automatic vel_word_type pid_outputs(input cmd_word_type w);
      longint meas, target, err, acc, der, kp, ki, kd, sum;
      vel_word_type r;
      r = '0;
      for (int a = 0; a < AXES; a++) begin
         meas   = longint'($signed(w[a*DATA_WIDTH +: DATA_WIDTH]));
         target = longint'($signed(w[(AXES+a)*DATA_WIDTH +: DATA_WIDTH]));
         case (a)
            0, 1: begin
               kp = gain_reg[CSR_KP_XY]; ki = gain_reg[CSR_KI_XY]; kd = gain_reg[CSR_KD_XY];
            end
            2: begin
               kp = gain_reg[CSR_KP_Z]; ki = gain_reg[CSR_KI_Z]; kd = gain_reg[CSR_KD_Z];
            end
            default: begin
               // yaw has no derivative term
               kp = gain_reg[CSR_KP_YAW]; ki = gain_reg[CSR_KI_YAW]; kd = 0;
            end
         endcase
         err = target - meas;
         acc = integ_q88[a] + err;
         if (acc >= longint'(INT_MAX)) acc = INT_MAX;
         else if (acc <= longint'(INT_MIN)) acc = INT_MIN;
         integ_q88[a] = acc;
         der = err - last_err[a];
         last_err[a] = err;
         // arithmetic shift floors toward minus infinity
         sum = (kp * err + ki * acc + kd * der) >>> GAIN_SHIFT;
         if (sum > 32767) sum = 32767;
         if (sum < -32768) sum = -32768;
         r[a*DATA_WIDTH +: DATA_WIDTH] = sum[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // Same measured/target pair on every axis
   function automatic cmd_word_type uniform_word(input sample_type meas, input sample_type target);
      cmd_word_type w;
      for (int a = 0; a < AXES; a++) begin
         w[a*DATA_WIDTH +: DATA_WIDTH]        = meas;
         w[(AXES+a)*DATA_WIDTH +: DATA_WIDTH] = target;
      end
      return w;
   endfunction

   function automatic sample_type edge_value();
      case ($urandom_range(0, 4))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'sh0001;
      endcase
   endfunction

   // Small tracking errors and full-range noise in equal shares, plus edge
   // values and zero-error words
   function automatic cmd_word_type random_word();
      cmd_word_type w;
      sample_type meas, target;
      int mode;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < AXES; a++) begin
         meas   = sample_type'($urandom_range(0, 65535));
         target = sample_type'($urandom_range(0, 65535));
         if (mode >= 4 && mode <= 7)
            target = meas + sample_type'($urandom_range(0, 1023) - 512);
         else if (mode == 8) begin
            meas   = edge_value();
            target = edge_value();
         end else if (mode == 9)
            target = meas;
         w[a*DATA_WIDTH +: DATA_WIDTH]        = meas;
         w[(AXES+a)*DATA_WIDTH +: DATA_WIDTH] = target;
      end
      return w;
   endfunction

   // Sender: one word per handshake, random gap bursts
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_vel.push_back(pid_outputs(req_tdata));
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               req_tdata  <= pending_cmds.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts and one long hold-off
   int  stall_left = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: capture at the rising edge, compare at the falling edge
   logic         rsp_taken = 1'b0;
   vel_word_type rsp_word  = '0;

   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      rsp_word  <= rsp_tdata;
   end

   always @(negedge clock) begin : check_vel
      vel_word_type want;
      if (rsp_taken) begin
         results_seen++;
         if (expected_vel.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("ERROR: response %h with no word outstanding", rsp_word);
         end else begin
            want = expected_vel.pop_front();
            for (int a = 0; a < AXES; a++) begin
               if (rsp_word[a*DATA_WIDTH +: DATA_WIDTH] !== want[a*DATA_WIDTH +: DATA_WIDTH]) begin
                  failures++;
                  if (failures <= REPORT_MAX)
                     $display("ERROR: response %0d %s expected %0d got %0d", results_seen,
                              axis_name[a], $signed(want[a*DATA_WIDTH +: DATA_WIDTH]),
                              $signed(rsp_word[a*DATA_WIDTH +: DATA_WIDTH]));
               end
            end
         end
      end
   end

   // Wait until every queued word has come back, then let the pipe settle
   task automatic drain_pipeline();
      @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_vel.size() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY) @(negedge clock);
   endtask

   // Write all eight gains, one per cycle, while the core is idle
   task automatic load_gain_set(input gain_type vals [CSR_COUNT]);
      for (int i = 0; i < CSR_COUNT; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= fapc_csr_type'(i);
         csr_wdata <= vals[i];
         gain_reg[i] = vals[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      gain_settings++;
   endtask

   task automatic random_gain_set(input bit narrow);
      gain_type vals [CSR_COUNT];
      for (int i = 0; i < CSR_COUNT; i++)
         vals[i] = narrow ? gain_type'($urandom_range(0, 4095) - 2048)
                          : gain_type'($urandom_range(0, 65535));
      load_gain_set(vals);
   endtask

   // Full-scale errors of both signs and a zero-error word lead each batch
   task automatic queue_random(input int count);
      pending_cmds.push_back(uniform_word(16'sh8000, 16'sh7FFF));
      pending_cmds.push_back(uniform_word(16'sh7FFF, 16'sh8000));
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sh0000));
      for (int i = 0; i < count; i++)
         pending_cmds.push_back(random_word());
   endtask

   // Stimulus phases
   initial begin : stimulus
      gain_type all_max [CSR_COUNT];
      gain_type all_min [CSR_COUNT];
      gain_type all_zero [CSR_COUNT];
      all_max  = '{default: 16'sh7FFF};
      all_min  = '{default: 16'sh8000};
      all_zero = '{default: 16'sh0000};

      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed words at the reset gains: clamp boundaries, floor on small
      // negative sums, full-scale errors and derivatives
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sh0000));
      pending_cmds.push_back(uniform_word(16'sh8000, 16'sh7FFF));
      pending_cmds.push_back(uniform_word(16'sh8000, 16'sh7FFF));
      pending_cmds.push_back(uniform_word(16'sh7FFF, 16'sh8000));
      pending_cmds.push_back(uniform_word(16'sh7FFF, 16'sh8000));
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sh0000));
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sd25600));
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sd25600));
      pending_cmds.push_back(uniform_word(16'sh0000, -16'sd1));
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sd1));
      pending_cmds.push_back(uniform_word(16'sh0000, -16'sd25600));
      pending_cmds.push_back(uniform_word(16'sh0000, -16'sd25600));
      pending_cmds.push_back(uniform_word(16'sh0000, -16'sd25600));
      pending_cmds.push_back(uniform_word(16'sh0001, 16'sh0000));
      pending_cmds.push_back(uniform_word(16'sh0000, 16'sh0001));
      pending_cmds.push_back(uniform_word(16'shFFFF, 16'sh0000));
      pending_cmds.push_back(uniform_word(16'sh7FFF, 16'sh7FFF));
      pending_cmds.push_back(uniform_word(16'sh8000, 16'sh8000));
      pending_cmds.push_back(uniform_word(16'shFFFF, 16'sh0001));
      pending_cmds.push_back(random_word());
      pending_cmds.push_back(random_word());
      drain_pipeline();

      // Random gains over the full range; the long hold-off falls in here
      random_gain_set(1'b0);
      queue_random(400);
      drain_pipeline();

      load_gain_set(all_max);
      queue_random(200);
      drain_pipeline();

      load_gain_set(all_min);
      queue_random(200);
      drain_pipeline();

      load_gain_set(all_zero);
      queue_random(50);
      drain_pipeline();

      random_gain_set(1'b1);
      queue_random(200);
      drain_pipeline();

      random_gain_set(1'b0);
      queue_random(200);
      drain_pipeline();

      // Last stretch at full rate on both sides
      idle_on = 1'b0;
      random_gain_set(1'b1);
      queue_random(500);
      drain_pipeline();

      repeat (4 * PIPE_LATENCY) @(negedge clock);
      if (expected_vel.size() != 0) begin
         failures++;
         $display("ERROR: %0d responses never arrived", expected_vel.size());
      end

      $display("Run covered %0d control words under %0d gain settings, %0d responses compared",
               words_taken, gain_settings, results_seen);
      $display("including full-scale errors, integrator clamping and output saturation");
      if (failures == 0)
         $display("four_axis_pid_controller_core test passed");
      else
         $display("four_axis_pid_controller_core test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("four_axis_pid_controller_core test failed");
      $finish;
   end

endmodule
